FILE: rtl/core/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants for the STUN binding response parser.
// ----------------------------------------------------------------------------
package sbrp_pkg;

    localparam int unsigned CountWidth = 17;

    localparam logic [31:0]           MAGIC_COOKIE    = 32'h2112_A442;
    localparam logic [15:0]           TYPE_BIND_OK    = 16'h0101;
    localparam logic [15:0]           ATTR_XOR_MAPPED = 16'h0020;
    localparam logic [15:0]           ATTR_MAPPED     = 16'h0001;
    localparam logic [7:0]            FAMILY_IPV4     = 8'h01;
    localparam logic [CountWidth-1:0] COUNT_MAX       = 17'h1_FFFF;
    localparam logic [CountWidth-1:0] HEADER_BYTES    = 17'd20;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_SHORT  = 3'd1,
        STATUS_WRONG_TYPE = 3'd2,
        STATUS_BAD_COOKIE = 3'd3,
        STATUS_ID_MISMATCH = 3'd4,
        STATUS_NO_ADDRESS = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } sbrp_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] endpoint_ip;
        logic [15:0] endpoint_port;
        logic        from_xor_attribute;
    } sbrp_rsp_t;

endpackage

FILE: rtl/core/sbrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbrp_cfg_regs
// APB register file holding the expected 96-bit transaction ID.
// ----------------------------------------------------------------------------
module sbrp_cfg_regs
    import sbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [31:0] txid_upper,
    output logic [63:0] txid_lower
);

    localparam logic REG_TXID_UPPER = 1'b0;
    localparam logic REG_TXID_LOWER = 1'b1;

    logic [31:0] txid_upper_reg;
    logic [63:0] txid_lower_reg;
    logic        wr_en;

    // registers sit on 8-byte boundaries; the low address bits select nothing
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txid_upper_reg <= '0;
            txid_lower_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3])
                REG_TXID_UPPER: txid_upper_reg <= pwdata[31:0];
                REG_TXID_LOWER: txid_lower_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_TXID_UPPER: prdata = {32'h0, txid_upper_reg};
            REG_TXID_LOWER: prdata = txid_lower_reg;
            default:        prdata = '0;
        endcase
    end

    assign txid_upper = txid_upper_reg;
    assign txid_lower = txid_lower_reg;

endmodule

FILE: rtl/core/sbrp_parser.sv
// ----------------------------------------------------------------------------
// sbrp_parser
// Per-datagram parse state: header checks, attribute walk and the result
// produced on the final byte.
// ----------------------------------------------------------------------------
module sbrp_parser
    import sbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  sbrp_req_t   req,
    input  logic [31:0] txid_upper,
    input  logic [63:0] txid_lower,
    output sbrp_rsp_t   rsp
);

    logic [CountWidth-1:0] byte_count_reg, byte_count_next;
    logic [31:0]           header_shift_reg, header_shift_next;
    logic [15:0]           message_length_reg, message_length_next;
    logic                  type_ok_reg, type_ok_next;
    logic                  cookie_ok_reg, cookie_ok_next;
    logic                  id_ok_reg, id_ok_next;
    logic                  walk_active_reg, walk_active_next;
    logic [CountWidth-1:0] next_start_reg, next_start_next;
    logic [15:0]           cur_type_reg, cur_type_next;
    logic [15:0]           cur_len_reg, cur_len_next;
    logic                  address_found_reg, address_found_next;
    logic [31:0]           found_address_reg, found_address_next;
    logic [15:0]           found_port_reg, found_port_next;
    logic                  found_is_xor_reg, found_is_xor_next;

    logic [CountWidth-1:0] pos;
    logic [7:0]            b;
    logic [31:0]           hs_shifted;
    logic [95:0]           txid_all;
    logic [3:0]            id_index;
    logic [6:0]            id_base;
    logic [7:0]            want_byte;
    logic [CountWidth-1:0] msg_end;
    logic [CountWidth-1:0] off;
    logic [15:0]           len_now;
    logic                  addr_type;

    // start of the following attribute: header plus body padded to 4 bytes
    function automatic logic [CountWidth-1:0] skip_target(
        input logic [CountWidth-1:0] start,
        input logic [15:0]           len
    );
        logic [CountWidth-1:0] padded;
        logic [CountWidth:0]   sum;
        padded = ({1'b0, len} + 17'd3) & ~17'd3;
        sum    = {1'b0, start} + 18'd4 + {1'b0, padded};
        return sum[CountWidth-1:0];
    endfunction

    assign pos        = byte_count_reg;
    assign b          = req.data_byte;
    assign hs_shifted = {header_shift_reg[23:0], b};
    assign txid_all   = {txid_upper, txid_lower};
    assign id_index   = 4'(pos[4:0] - 5'd8);
    assign id_base    = 7'd88 - {id_index, 3'b000};
    assign want_byte  = txid_all[id_base +: 8];
    assign msg_end    = HEADER_BYTES + {1'b0, message_length_reg};
    assign off        = pos - next_start_reg;
    assign len_now    = {cur_len_reg[15:8], b};
    assign addr_type  = (cur_type_reg == ATTR_XOR_MAPPED) ||
                        (cur_type_reg == ATTR_MAPPED);

    always_comb
    begin
        header_shift_next   = header_shift_reg;
        message_length_next = message_length_reg;
        type_ok_next        = type_ok_reg;
        cookie_ok_next      = cookie_ok_reg;
        id_ok_next          = id_ok_reg;
        walk_active_next    = walk_active_reg;
        next_start_next     = next_start_reg;
        cur_type_next       = cur_type_reg;
        cur_len_next        = cur_len_reg;
        address_found_next  = address_found_reg;
        found_address_next  = found_address_reg;
        found_port_next     = found_port_reg;
        found_is_xor_next   = found_is_xor_reg;
        rsp                 = '0;

        if (pos < HEADER_BYTES)
        begin
            header_shift_next = hs_shifted;
            if (pos == 17'd1)
                type_ok_next = (hs_shifted[15:0] == TYPE_BIND_OK);
            else if (pos == 17'd3)
                message_length_next = hs_shifted[15:0];
            else if (pos == 17'd7)
                cookie_ok_next = (hs_shifted == MAGIC_COOKIE);
            else if (pos >= 17'd8)
            begin
                if (b != want_byte)
                    id_ok_next = 1'b0;
            end
        end
        else if (walk_active_reg && !address_found_reg && pos >= next_start_reg)
        begin
            unique case (off)
                17'd0:
                begin
                    if (({1'b0, next_start_reg} + 18'd4) > {1'b0, msg_end})
                        walk_active_next = 1'b0;
                    else
                        cur_type_next = {b, 8'h00};
                end
                17'd1: cur_type_next = {cur_type_reg[15:8], b};
                17'd2: cur_len_next = {b, 8'h00};
                17'd3:
                begin
                    cur_len_next = len_now;
                    if (({1'b0, next_start_reg} + 18'd4 + {2'b00, len_now})
                        > {1'b0, msg_end})
                        walk_active_next = 1'b0;
                    else if (!(addr_type && len_now >= 16'd8))
                        next_start_next = skip_target(next_start_reg, len_now);
                end
                17'd5:
                begin
                    if (b != FAMILY_IPV4)
                        next_start_next = skip_target(next_start_reg, cur_len_reg);
                end
                17'd6: found_port_next = {b, 8'h00};
                17'd7: found_port_next = {found_port_reg[15:8], b};
                17'd8, 17'd9, 17'd10:
                    found_address_next = {found_address_reg[23:0], b};
                17'd11:
                begin
                    found_address_next = {found_address_reg[23:0], b};
                    address_found_next = 1'b1;
                    found_is_xor_next  = (cur_type_reg == ATTR_XOR_MAPPED);
                end
                default: ;
            endcase
        end

        byte_count_next = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 17'd1
                                                       : byte_count_reg;

        // verdict, checked in priority order
        if (byte_count_next < HEADER_BYTES)
            rsp.status = STATUS_TOO_SHORT;
        else if (!type_ok_next)
            rsp.status = STATUS_WRONG_TYPE;
        else if ((HEADER_BYTES + {1'b0, message_length_next}) > byte_count_next)
            rsp.status = STATUS_TOO_SHORT;
        else if (!cookie_ok_next)
            rsp.status = STATUS_BAD_COOKIE;
        else if (!id_ok_next)
            rsp.status = STATUS_ID_MISMATCH;
        else if (!address_found_next)
            rsp.status = STATUS_NO_ADDRESS;
        else
        begin
            rsp.status = STATUS_OK;
            if (found_is_xor_next)
            begin
                rsp.endpoint_ip        = found_address_next ^ MAGIC_COOKIE;
                rsp.endpoint_port      = found_port_next ^ MAGIC_COOKIE[31:16];
                rsp.from_xor_attribute = 1'b1;
            end
            else
            begin
                rsp.endpoint_ip   = found_address_next;
                rsp.endpoint_port = found_port_next;
            end
        end

        // drop all per-datagram state after the final byte
        if (req.end_of_datagram)
        begin
            byte_count_next     = '0;
            header_shift_next   = '0;
            message_length_next = '0;
            type_ok_next        = 1'b0;
            cookie_ok_next      = 1'b0;
            id_ok_next          = 1'b1;
            walk_active_next    = 1'b1;
            next_start_next     = HEADER_BYTES;
            cur_type_next       = '0;
            cur_len_next        = '0;
            address_found_next  = 1'b0;
            found_address_next  = '0;
            found_port_next     = '0;
            found_is_xor_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            header_shift_reg   <= '0;
            message_length_reg <= '0;
            type_ok_reg        <= 1'b0;
            cookie_ok_reg      <= 1'b0;
            id_ok_reg          <= 1'b1;
            walk_active_reg    <= 1'b1;
            next_start_reg     <= HEADER_BYTES;
            cur_type_reg       <= '0;
            cur_len_reg        <= '0;
            address_found_reg  <= 1'b0;
            found_address_reg  <= '0;
            found_port_reg     <= '0;
            found_is_xor_reg   <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg     <= byte_count_next;
            header_shift_reg   <= header_shift_next;
            message_length_reg <= message_length_next;
            type_ok_reg        <= type_ok_next;
            cookie_ok_reg      <= cookie_ok_next;
            id_ok_reg          <= id_ok_next;
            walk_active_reg    <= walk_active_next;
            next_start_reg     <= next_start_next;
            cur_type_reg       <= cur_type_next;
            cur_len_reg        <= cur_len_next;
            address_found_reg  <= address_found_next;
            found_address_reg  <= found_address_next;
            found_port_reg     <= found_port_next;
            found_is_xor_reg   <= found_is_xor_next;
        end
    end

endmodule

FILE: rtl/core/stun_binding_response_parser_unit.sv
// ----------------------------------------------------------------------------
// stun_binding_response_parser_unit
// Streams a received STUN datagram byte by byte and reports the mapped
// public IPv4 endpoint from a binding success response.
// ----------------------------------------------------------------------------
// One request carries one datagram byte; the request flagged as the final
// byte yields exactly one response with the status and, on success, the
// public address and port (XOR form already unmasked). Requests are taken
// at one per cycle: each byte passes from an input register through the
// parse logic; the response to a final byte goes into the response register.
// Only a final byte waits, and only while an earlier response is still held
// in the output register and stalled. The user must set the expected
// transaction ID over APB (txid_upper at 0x0, txid_lower at 0x8) only while
// no datagram is in flight; the block itself does not enforce this.
module stun_binding_response_parser_unit
    import sbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  sbrp_req_t   req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output sbrp_rsp_t   rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic        req_valid_reg;
    sbrp_req_t   req_data_reg;
    logic        rsp_valid_reg;
    sbrp_rsp_t   rsp_data_reg;
    sbrp_rsp_t   parse_rsp;
    logic        advance;
    logic [31:0] txid_upper;
    logic [63:0] txid_lower;

    sbrp_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .txid_upper (txid_upper),
        .txid_lower (txid_lower)
    );

    sbrp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .req        (req_data_reg),
        .txid_upper (txid_upper),
        .txid_lower (txid_lower),
        .rsp        (parse_rsp)
    );

    // hold a final byte only while the response slot is occupied and stalled
    assign advance   = req_valid_reg &&
                       !(req_data_reg.end_of_datagram && rsp_valid_reg && rsp_stall);
    assign req_stall = req_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                req_valid_reg <= req_valid;
            if (advance && req_data_reg.end_of_datagram)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            req_data_reg <= req_data;
        if (advance && req_data_reg.end_of_datagram)
            rsp_data_reg <= parse_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

FILE: sim/mapped_endpoint_checker.sv
// ----------------------------------------------------------------------------
// mapped_endpoint_checker
// Watches the request, response and APB ports of the STUN binding response
// parser, predicts the verdict of every datagram and compares it field by
// field with the responses that the parser returns.
// ----------------------------------------------------------------------------
module mapped_endpoint_checker
    import sbrp_pkg::*;
#(
    parameter logic [3:0] TXID_UPPER_ADDR = 4'h0,
    parameter logic [3:0] TXID_LOWER_ADDR = 4'h8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  sbrp_req_t   req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  sbrp_rsp_t   rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] txid_upper;
    logic [63:0] txid_lower;

    int unsigned rx_count;
    logic [31:0] header_bits;
    logic [15:0] declared_len;
    logic        type_good;
    logic        cookie_good;
    logic        txid_good;
    logic        walking;
    int unsigned attr_start;
    logic [15:0] cur_type;
    logic [15:0] cur_len;
    logic        addr_seen;
    logic        addr_is_xor;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;

    sbrp_rsp_t   expected_verdicts[$];
    sbrp_rsp_t   oldest;
    int          fails;

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endtask

    task automatic clear_datagram();
        rx_count     = 0;
        header_bits  = '0;
        declared_len = '0;
        type_good    = 1'b0;
        cookie_good  = 1'b0;
        txid_good    = 1'b1;
        walking      = 1'b1;
        attr_start   = 20;
        cur_type     = '0;
        cur_len      = '0;
        addr_seen    = 1'b0;
        addr_is_xor  = 1'b0;
        mapped_ip    = '0;
        mapped_port  = '0;
    endtask

    // advance to the next attribute, body padded to four bytes
    task automatic skip_attribute();
        int unsigned padded;
        padded     = (32'(cur_len) + 32'd3) & ~32'd3;
        attr_start = (attr_start + 4 + padded) & 32'(COUNT_MAX);
    endtask

    task automatic parse_stun_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned msg_end;
        int unsigned off;
        int unsigned total;
        logic [95:0] txid_all;
        sbrp_rsp_t   verdict;
        pos      = rx_count;
        txid_all = {txid_upper, txid_lower};
        if (pos < 20) begin
            header_bits = {header_bits[23:0], b};
            if (pos == 1)
                type_good = (header_bits[15:0] == TYPE_BIND_OK);
            else if (pos == 3)
                declared_len = header_bits[15:0];
            else if (pos == 7)
                cookie_good = (header_bits == MAGIC_COOKIE);
            else if (pos >= 8 && b != txid_all[8*(19-pos) +: 8])
                txid_good = 1'b0;
        end
        else if (walking && !addr_seen && pos >= attr_start) begin
            msg_end = 20 + declared_len;
            off     = pos - attr_start;
            case (off)
                0: begin
                    if (attr_start + 4 > msg_end)
                        walking = 1'b0;
                    else
                        cur_type = {b, 8'h00};
                end
                1: cur_type[7:0] = b;
                2: cur_len = {b, 8'h00};
                3: begin
                    cur_len[7:0] = b;
                    if (attr_start + 4 + cur_len > msg_end)
                        walking = 1'b0;
                    else if (!((cur_type == ATTR_XOR_MAPPED || cur_type == ATTR_MAPPED)
                               && cur_len >= 16'd8))
                        skip_attribute();
                end
                5: begin
                    if (b != FAMILY_IPV4)
                        skip_attribute();
                end
                6: mapped_port[15:8] = b;
                7: mapped_port[7:0] = b;
                8, 9, 10, 11: begin
                    mapped_ip = {mapped_ip[23:0], b};
                    if (off == 11) begin
                        addr_seen   = 1'b1;
                        addr_is_xor = (cur_type == ATTR_XOR_MAPPED);
                    end
                end
                default: ;
            endcase
        end

        if (rx_count < COUNT_MAX)
            rx_count++;

        if (last) begin
            total   = rx_count;
            verdict = '0;
            if (total < 20)
                verdict.status = STATUS_TOO_SHORT;
            else if (!type_good)
                verdict.status = STATUS_WRONG_TYPE;
            else if (20 + declared_len > total)
                verdict.status = STATUS_TOO_SHORT;
            else if (!cookie_good)
                verdict.status = STATUS_BAD_COOKIE;
            else if (!txid_good)
                verdict.status = STATUS_ID_MISMATCH;
            else if (!addr_seen)
                verdict.status = STATUS_NO_ADDRESS;
            else begin
                verdict.status = STATUS_OK;
                if (addr_is_xor) begin
                    verdict.endpoint_ip        = mapped_ip ^ MAGIC_COOKIE;
                    verdict.endpoint_port      = mapped_port ^ MAGIC_COOKIE[31:16];
                    verdict.from_xor_attribute = 1'b1;
                end
                else begin
                    verdict.endpoint_ip   = mapped_ip;
                    verdict.endpoint_port = mapped_port;
                end
            end
            expected_verdicts.push_back(verdict);
            clear_datagram();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            txid_upper = '0;
            txid_lower = '0;
            clear_datagram();
            expected_verdicts.delete();
            fails = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == TXID_UPPER_ADDR)
                    txid_upper = pwdata[31:0];
                else if (paddr == TXID_LOWER_ADDR)
                    txid_lower = pwdata;
            end

            if (rsp_valid && !rsp_stall) begin
                if (expected_verdicts.size() == 0)
                    note_mismatch($sformatf("response with no datagram pending, status %0d",
                                            rsp_data.status));
                else begin
                    oldest = expected_verdicts.pop_front();
                    if (rsp_data.status !== oldest.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                rsp_data.status, oldest.status));
                    if (rsp_data.endpoint_ip !== oldest.endpoint_ip)
                        note_mismatch($sformatf("endpoint_ip %h, want %h",
                                                rsp_data.endpoint_ip, oldest.endpoint_ip));
                    if (rsp_data.endpoint_port !== oldest.endpoint_port)
                        note_mismatch($sformatf("endpoint_port %h, want %h",
                                                rsp_data.endpoint_port,
                                                oldest.endpoint_port));
                    if (rsp_data.from_xor_attribute !== oldest.from_xor_attribute)
                        note_mismatch($sformatf("from_xor_attribute %b, want %b",
                                                rsp_data.from_xor_attribute,
                                                oldest.from_xor_attribute));
                end
            end

            if (req_valid && !req_stall)
                parse_stun_byte(req_data.data_byte, req_data.end_of_datagram);

            mismatch_count <= fails;
            pending_count  <= expected_verdicts.size();
        end
    end

endmodule

FILE: sim/stun_binding_response_parser_unit_test.sv
// ----------------------------------------------------------------------------
// stun_binding_response_parser_unit_test
// Streams directed and random STUN datagrams into the parser under several
// transaction ID settings, with random gaps on the request side and random
// stalls on the response side; the checker beside the parser does the scoring.
// ----------------------------------------------------------------------------
module stun_binding_response_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbrp_pkg::*;

    localparam logic [3:0]  ADDR_TXID_UPPER = 4'h0;
    localparam logic [3:0]  ADDR_TXID_LOWER = 4'h8;
    localparam logic [7:0]  FAMILY_IPV6     = 8'h02;
    localparam logic [15:0] ATTR_SOFTWARE   = 16'h8022;
    localparam int          WATCHDOG_LIMIT  = 4000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    sbrp_req_t   req_data  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    sbrp_rsp_t   rsp_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [63:0] pwdata    = '0;
    logic [63:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_count;
    int          idle_cycles = 0;

    logic [31:0] txid_hi = '0;
    logic [63:0] txid_lo = '0;
    logic [7:0]  dgram[$];

    stun_binding_response_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    mapped_endpoint_checker #(
        .TXID_UPPER_ADDR (ADDR_TXID_UPPER),
        .TXID_LOWER_ADDR (ADDR_TXID_LOWER)
    ) endpoint_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // end the run when neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stun_binding_response_parser_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int hold;
        int run;
        @(posedge clk);
        forever begin
            hold = idle_gap();
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    task automatic put_word(input logic [31:0] v, input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--)
            dgram.push_back(v[8*k +: 8]);
    endtask

    task automatic open_header(input logic [15:0] mtype, input logic [31:0] cookie);
        dgram.delete();
        put_word({16'h0, mtype}, 2);
        put_word(32'h0, 2);
        put_word(cookie, 4);
        put_word(txid_hi, 4);
        put_word(txid_lo[63:32], 4);
        put_word(txid_lo[31:0], 4);
    endtask

    // family goes in the second body byte; pad the body to four bytes
    task automatic put_attribute(input logic [15:0] atype, input int alen,
                                 input logic [7:0] family);
        put_word({16'h0, atype}, 2);
        put_word(alen, 2);
        for (int k = 0; k < alen; k++)
            dgram.push_back(k == 1 ? family : 8'($urandom));
        while (dgram.size() % 4 != 0)
            dgram.push_back(8'($urandom));
    endtask

    task automatic seal_length(input int delta);
        int v;
        v = dgram.size() - 20 + delta;
        dgram[2] = v[15:8];
        dgram[3] = v[7:0];
    endtask

    task automatic add_random_attribute();
        logic [15:0] addr_type;
        addr_type = $urandom_range(0, 1) ? ATTR_XOR_MAPPED : ATTR_MAPPED;
        case ($urandom_range(0, 9))
            0, 1, 2: put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
            3, 4:    put_attribute(ATTR_MAPPED, 8, FAMILY_IPV4);
            5:       put_attribute(addr_type, 20, FAMILY_IPV6);
            6:       put_attribute(addr_type, $urandom_range(0, 7), FAMILY_IPV4);
            7:       put_attribute(addr_type, $urandom_range(9, 16), FAMILY_IPV4);
            8:       put_attribute(addr_type, 8, 8'($urandom));
            default: put_attribute(16'($urandom), $urandom_range(0, 12), 8'($urandom));
        endcase
    endtask

    // mostly well-formed responses, the rest broken or pure noise
    task automatic make_random_datagram();
        int          r;
        int          n;
        logic [15:0] mtype;
        logic [31:0] cookie;
        r = $urandom_range(0, 99);
        if (r >= 91) begin
            dgram.delete();
            n = $urandom_range(1, 48);
            repeat (n) dgram.push_back(8'($urandom));
            return;
        end
        mtype  = TYPE_BIND_OK;
        cookie = MAGIC_COOKIE;
        if (r >= 78 && r <= 80)
            mtype ^= 16'd1 << $urandom_range(0, 15);
        if (r >= 81 && r <= 83)
            cookie ^= 32'd1 << $urandom_range(0, 31);
        open_header(mtype, cookie);
        if (r >= 84 && r <= 86)
            dgram[$urandom_range(8, 19)] ^= 8'd1 << $urandom_range(0, 7);
        n = $urandom_range(0, 4);
        repeat (n) add_random_attribute();
        if (r >= 65 && r <= 69)
            seal_length($urandom_range(1, 16));
        else if (r >= 70 && r <= 74) begin
            n = $urandom_range(0, (dgram.size() - 20 < 16) ? dgram.size() - 20 : 16);
            seal_length(-n);
        end
        else
            seal_length(0);
        if (r >= 75 && r <= 77)
            repeat ($urandom_range(1, 8)) dgram.push_back(8'($urandom));
        if (r >= 87 && r <= 90) begin
            n = $urandom_range(1, dgram.size() - 1);
            repeat (n) void'(dgram.pop_back());
        end
    endtask

    // valid stays high between back-to-back requests
    task automatic send_datagram(input bit quiet);
        int gap;
        foreach (dgram[i]) begin
            gap = quiet ? 0 : idle_gap();
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            req_data  <= '{data_byte: dgram[i], end_of_datagram: (i == dgram.size() - 1)};
            @(posedge clk);
            while (req_stall) @(posedge clk);
        end
    endtask

    task automatic drain_responses(input int settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [31:0] hi, input logic [63:0] lo);
        drain_responses(4);
        apb_write(ADDR_TXID_UPPER, {32'h0, hi});
        apb_write(ADDR_TXID_LOWER, lo);
        txid_hi = hi;
        txid_lo = lo;
    endtask

    initial begin
        int          sent_bytes;
        int          sent_dgrams;
        logic [31:0] hi;
        logic [63:0] lo;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed datagrams, transaction ID still at its reset value
        dgram.delete();
        dgram.push_back(8'hFF);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        void'(dgram.pop_back());
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        // first address wins
        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_MAPPED, 8, FAMILY_IPV4);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        // skip IPv6, unknown types and short addresses
        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 20, FAMILY_IPV6);
        put_attribute(ATTR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_SOFTWARE, 1, 8'h00);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_MAPPED, 4, FAMILY_IPV4);
        put_attribute(ATTR_XOR_MAPPED, 12, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        // declared length beyond the datagram
        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(4);
        send_datagram(1'b0);

        // attribute header crosses the declared end
        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(22 - dgram.size());
        send_datagram(1'b0);

        // attribute body crosses the declared end
        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(-4);
        send_datagram(1'b0);

        open_header(16'h0111, MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, ~MAGIC_COOKIE);
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        open_header(TYPE_BIND_OK, MAGIC_COOKIE);
        dgram[19] ^= 8'h80;
        put_attribute(ATTR_XOR_MAPPED, 8, FAMILY_IPV4);
        seal_length(0);
        send_datagram(1'b0);

        dgram.delete();
        repeat (20) dgram.push_back(8'hFF);
        send_datagram(1'b0);

        // random datagrams under several transaction IDs
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    hi = '1;
                    lo = '1;
                end
                3: begin
                    hi = '0;
                    lo = '0;
                end
                default: begin
                    hi = $urandom;
                    lo = {$urandom, $urandom};
                end
            endcase
            reconfigure(hi, lo);
            sent_bytes  = 0;
            sent_dgrams = 0;
            while (sent_dgrams < 3 || sent_bytes < 130) begin
                make_random_datagram();
                sent_bytes += dgram.size();
                send_datagram($urandom_range(0, 4) == 0);
                sent_dgrams++;
            end
        end

        drain_responses(16);
        if (mismatch_count == 0 && pending_count == 0)
            $display("stun_binding_response_parser_unit verification clean");
        else
            $display("stun_binding_response_parser_unit verification failed");
        $finish;
    end

endmodule
